// File: rtl/core/naw_pkg.sv
package naw_pkg;

    localparam int NUM_NB         = 8;   // neighbors, raster order nw,n,ne,w,e,sw,s,se
    localparam int NUM_PIX        = 9;   // window pixels, raster order
    localparam int CENTER         = 4;
    localparam int DEF_PIXEL_BITS = 8;
    localparam int KBITS          = 8;   // exponent index bits, 1/16 steps up to 255

    // pipeline depths of the sections
    localparam int FRONT_LAT = 6;
    localparam int WL_LAT    = 2 * KBITS + 1;
    localparam int SUM_LAT   = 3;
    localparam int QD_LAT    = 18;

    typedef struct packed {
        logic              feature;
        logic [NUM_NB-1:0] mask;
    } t_side;

    typedef struct packed {
        logic              feature;
        logic [NUM_NB-1:0] mask;
        logic              zero;
    } t_tail;

endpackage

// File: rtl/core/naw_front.sv
module naw_front #(
    parameter int PIXEL_BITS = naw_pkg::DEF_PIXEL_BITS
) (
    input  logic                            i_clk,
    input  logic [PIXEL_BITS-1:0]           i_pix [naw_pkg::NUM_PIX],
    input  logic [3:0]                      i_border,
    input  logic                            i_feature,
    output logic [naw_pkg::NUM_NB-1:0]      o_mask,
    output logic                            o_feature,
    output logic signed [2*PIXEL_BITS+16:0] o_wl [naw_pkg::NUM_NB],
    output logic [2*PIXEL_BITS+12:0]        o_num [naw_pkg::NUM_NB],
    output logic [2*PIXEL_BITS+7:0]         o_div3
);
    import naw_pkg::*;

    localparam int P    = PIXEL_BITS;
    localparam int QW   = P + 1;
    localparam int SQW  = 2 * P + 2;
    localparam int SUW  = P + 4;
    localparam int SSW  = 2 * P + 4;
    localparam int DW   = 2 * P + 7;
    localparam int AW   = P + 7;
    localparam int ABW  = 2 * AW;
    localparam int DSQW = 2 * P;
    localparam int NUMW = 2 * P + 13;
    localparam int D3W  = 2 * P + 8;
    localparam int T1W  = 2 * P + 15;
    localparam int WW   = 2 * P + 17;

    function automatic int nb_pos(input int i);
        return (i < CENTER) ? i : i + 1;
    endfunction

    // bit0 top row, bit1 bottom row, bit2 left column, bit3 right column gone
    function automatic logic [NUM_NB-1:0] nb_present(input logic [3:0] b);
        return {~(b[1] | b[3]), ~b[1], ~(b[1] | b[2]), ~b[3],
                ~b[2], ~(b[0] | b[3]), ~b[0], ~(b[0] | b[2])};
    endfunction

    // 80*n*(n-1)
    function automatic logic [12:0] exp_scale(input logic [3:0] n);
        logic [12:0] v;
        case (n)
            4'd2:    v = 13'd160;
            4'd3:    v = 13'd480;
            4'd4:    v = 13'd960;
            4'd5:    v = 13'd1600;
            4'd6:    v = 13'd2400;
            4'd7:    v = 13'd3360;
            4'd8:    v = 13'd4480;
            4'd9:    v = 13'd5760;
            default: v = 13'd0;
        endcase
        return v;
    endfunction

    logic [NUM_NB-1:0]  mask_in;
    logic [NUM_PIX-1:0] pres_in;
    logic [QW-1:0]      q_in [NUM_PIX];

    always_comb begin
        mask_in = nb_present(i_border);
        for (int i = 0; i < NUM_NB; i++) pres_in[nb_pos(i)] = mask_in[i];
        pres_in[CENTER] = 1'b1;
        for (int p = 0; p < NUM_PIX; p++) q_in[p] = QW'(i_pix[p]) + QW'(1);
    end

    // stage 1: offset pixels, squares
    logic [QW-1:0]      r_q1 [NUM_PIX];
    logic [SQW-1:0]     r_sq1 [NUM_PIX];
    logic [NUM_PIX-1:0] r_pres1;
    logic [NUM_NB-1:0]  r_mask1;
    logic [3:0]         r_n1;
    logic               r_ft1;

    always_ff @(posedge i_clk) begin
        for (int p = 0; p < NUM_PIX; p++) begin
            r_q1[p]  <= q_in[p];
            r_sq1[p] <= pres_in[p] ? SQW'(q_in[p]) * SQW'(q_in[p]) : '0;
        end
        r_pres1 <= pres_in;
        r_mask1 <= mask_in;
        r_n1    <= 4'($countones(mask_in)) + 4'd1;
        r_ft1   <= i_feature;
    end

    // stage 2: sums
    logic [SUW-1:0]    n_sum2;
    logic [SSW-1:0]    n_sumsq2;
    logic [QW-1:0]     r_q2 [NUM_PIX];
    logic [SUW-1:0]    r_sum2;
    logic [SSW-1:0]    r_sumsq2;
    logic [NUM_NB-1:0] r_mask2;
    logic [3:0]        r_n2;
    logic              r_ft2;

    always_comb begin
        n_sum2   = '0;
        n_sumsq2 = '0;
        for (int p = 0; p < NUM_PIX; p++) begin
            n_sum2   = n_sum2 + (r_pres1[p] ? SUW'(r_q1[p]) : '0);
            n_sumsq2 = n_sumsq2 + SSW'(r_sq1[p]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_q2     <= r_q1;
        r_sum2   <= n_sum2;
        r_sumsq2 <= n_sumsq2;
        r_mask2  <= r_mask1;
        r_n2     <= r_n1;
        r_ft2    <= r_ft1;
    end

    // stage 3: centered terms, N*sum(q^2), S^2, squared differences
    logic [5:0]           n5_3;
    logic [QW-1:0]        df3 [NUM_NB];
    logic signed [AW-1:0] r_a3 [NUM_NB];
    logic signed [AW-1:0] r_b3;
    logic [DSQW-1:0]      r_dsq3 [NUM_NB];
    logic [12:0]          r_c3;
    logic [DW-1:0]        r_nss3;
    logic [DW-1:0]        r_sqs3;
    logic [3:0]           r_n3;
    logic [NUM_NB-1:0]    r_mask3;
    logic                 r_ft3;

    always_comb begin
        n5_3 = 6'(r_n2) * 6'd5;
        for (int i = 0; i < NUM_NB; i++) begin
            df3[i] = (r_q2[nb_pos(i)] >= r_q2[CENTER]) ? r_q2[nb_pos(i)] - r_q2[CENTER]
                                                       : r_q2[CENTER] - r_q2[nb_pos(i)];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_NB; i++) begin
            r_a3[i]   <= $signed(AW'(n5_3) * AW'(r_q2[nb_pos(i)]) - AW'(r_sum2) * AW'(3));
            r_dsq3[i] <= DSQW'(df3[i][P-1:0]) * DSQW'(df3[i][P-1:0]);
        end
        r_b3    <= $signed(AW'(n5_3) * AW'(r_q2[CENTER]) - AW'(r_sum2) * AW'(3));
        r_c3    <= exp_scale(r_n2);
        r_nss3  <= DW'(r_n2) * DW'(r_sumsq2);
        r_sqs3  <= DW'(r_sum2) * DW'(r_sum2);
        r_n3    <= r_n2;
        r_mask3 <= r_mask2;
        r_ft3   <= r_ft2;
    end

    // stage 4: D with flat-window clamp, A*B, exponent numerators
    logic [DW-1:0]         dif4;
    logic [DW-1:0]         r_d4;
    logic signed [ABW-1:0] r_ab4 [NUM_NB];
    logic [NUMW-1:0]       r_num4 [NUM_NB];
    logic [7:0]            r_n25_4;
    logic [3:0]            r_nm1_4;
    logic [NUM_NB-1:0]     r_mask4;
    logic                  r_ft4;

    assign dif4 = r_nss3 - r_sqs3;

    always_ff @(posedge i_clk) begin
        r_d4 <= (dif4 == '0) ? DW'(1) : dif4;
        for (int i = 0; i < NUM_NB; i++) begin
            r_ab4[i]  <= r_a3[i] * r_b3;
            r_num4[i] <= NUMW'(r_dsq3[i]) * NUMW'(r_c3);
        end
        r_n25_4 <= 8'(r_n3) * 8'd25;
        r_nm1_4 <= r_n3 - 4'd1;
        r_mask4 <= r_mask3;
        r_ft4   <= r_ft3;
    end

    // stage 5: 25*N*D, (N-1)*A*B, 3*D
    logic [T1W-1:0]       r_t1_5;
    logic signed [WW-1:0] r_t2_5 [NUM_NB];
    logic [D3W-1:0]       r_div3_5;
    logic [NUMW-1:0]      r_num5 [NUM_NB];
    logic [NUM_NB-1:0]    r_mask5;
    logic                 r_ft5;

    always_ff @(posedge i_clk) begin
        r_t1_5 <= T1W'(r_n25_4) * T1W'(r_d4);
        for (int i = 0; i < NUM_NB; i++) begin
            r_t2_5[i] <= WW'(r_ab4[i]) * $signed({1'b0, r_nm1_4});
        end
        r_div3_5 <= D3W'({r_d4, 1'b0}) + D3W'(r_d4);
        r_num5   <= r_num4;
        r_mask5  <= r_mask4;
        r_ft5    <= r_ft4;
    end

    // stage 6: linear weights
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_NB; i++) begin
            o_wl[i] <= $signed({2'b00, r_t1_5}) + r_t2_5[i];
        end
        o_num     <= r_num5;
        o_div3    <= r_div3_5;
        o_mask    <= r_mask5;
        o_feature <= r_ft5;
    end

endmodule

// File: rtl/core/naw_wlane.sv
module naw_wlane #(
    parameter int PIXEL_BITS = naw_pkg::DEF_PIXEL_BITS
) (
    input  logic                            i_clk,
    input  logic [2*PIXEL_BITS+12:0]        i_num,
    input  logic [2*PIXEL_BITS+7:0]         i_div3,
    input  logic signed [2*PIXEL_BITS+16:0] i_wl,
    input  logic                            i_mode,
    input  logic                            i_pres,
    output logic signed [2*PIXEL_BITS+16:0] o_w
);
    import naw_pkg::*;

    localparam int NUMW = 2 * PIXEL_BITS + 13;
    localparam int D3W  = 2 * PIXEL_BITS + 8;
    localparam int CW   = D3W + KBITS;
    localparam int WW   = 2 * PIXEL_BITS + 17;
    localparam int NST  = 2 * KBITS;

    // exp(-2^j/16) in Q0.16
    localparam logic [15:0] EXP_F [KBITS] = '{
        16'd61565, 16'd57835, 16'd51039, 16'd39750,
        16'd24109, 16'd8869,  16'd1200,  16'd22
    };

    typedef struct packed {
        logic [NUMW-1:0]      rem;
        logic [D3W-1:0]       dv;
        logic [KBITS-1:0]     k;
        logic                 ovf;
        logic [16:0]          w;
        logic signed [WW-1:0] wl;
        logic                 mode;
        logic                 pres;
    } t_lst;

    t_lst r_st [NST];
    t_lst n_st [NST];

    // first KBITS stages: restoring divide for the exponent index,
    // next KBITS stages: one table factor each
    for (genvar s = 0; s < NST; s++) begin : g_st
        t_lst src;
        if (s == 0) begin : g_in
            assign src = '{rem: i_num, dv: i_div3, k: '0, ovf: 1'b0, w: '0,
                           wl: i_wl, mode: i_mode, pres: i_pres};
        end else begin : g_prev
            assign src = r_st[s-1];
        end

        if (s < KBITS) begin : g_div
            localparam int B = KBITS - 1 - s;
            always_comb begin
                logic ovf_c;
                logic ge;
                ovf_c = (s == 0) ? (CW'(src.rem) >= (CW'(src.dv) << KBITS)) : src.ovf;
                ge    = CW'(src.rem) >= (CW'(src.dv) << B);
                n_st[s]     = src;
                n_st[s].ovf = ovf_c;
                if (ge && !ovf_c) begin
                    n_st[s].rem  = NUMW'(CW'(src.rem) - (CW'(src.dv) << B));
                    n_st[s].k[B] = 1'b1;
                end
            end
        end else begin : g_exp
            localparam int E = s - KBITS;
            always_comb begin
                logic [16:0] w_in;
                logic [33:0] prod;
                w_in = (s == KBITS) ? (src.ovf ? 17'd0 : 17'h10000) : src.w;
                prod = 34'(w_in) * 34'(EXP_F[E]) + 34'd32768;
                n_st[s]   = src;
                n_st[s].w = src.k[E] ? prod[32:16] : w_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_st <= n_st;
        if (!r_st[NST-1].pres) begin
            o_w <= '0;
        end else if (r_st[NST-1].mode) begin
            o_w <= $signed(WW'(r_st[NST-1].w));
        end else begin
            o_w <= r_st[NST-1].wl;
        end
    end

endmodule

// File: rtl/core/naw_sum.sv
module naw_sum #(
    parameter int PIXEL_BITS = naw_pkg::DEF_PIXEL_BITS
) (
    input  logic                            i_clk,
    input  logic signed [2*PIXEL_BITS+16:0] i_w [naw_pkg::NUM_NB],
    output logic signed [2*PIXEL_BITS+16:0] o_w [naw_pkg::NUM_NB],
    output logic signed [2*PIXEL_BITS+19:0] o_den
);
    import naw_pkg::*;

    localparam int SW = 2 * PIXEL_BITS + 20;
    localparam int WW = 2 * PIXEL_BITS + 17;

    logic signed [SW-1:0] r_p1 [NUM_NB/2];
    logic signed [SW-1:0] r_p2 [NUM_NB/4];
    logic signed [WW-1:0] r_w1 [NUM_NB];
    logic signed [WW-1:0] r_w2 [NUM_NB];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_NB / 2; i++) begin
            r_p1[i] <= SW'(i_w[2*i]) + SW'(i_w[2*i+1]);
        end
        for (int i = 0; i < NUM_NB / 4; i++) begin
            r_p2[i] <= r_p1[2*i] + r_p1[2*i+1];
        end
        o_den <= r_p2[0] + r_p2[1];
        r_w1  <= i_w;
        r_w2  <= r_w1;
        o_w   <= r_w2;
    end

endmodule

// File: rtl/core/naw_qdiv.sv
module naw_qdiv #(
    parameter int PIXEL_BITS = naw_pkg::DEF_PIXEL_BITS
) (
    input  logic                            i_clk,
    input  logic signed [2*PIXEL_BITS+16:0] i_w,
    input  logic signed [2*PIXEL_BITS+19:0] i_den,
    output logic signed [15:0]              o_coef
);
    import naw_pkg::*;

    localparam int WW   = 2 * PIXEL_BITS + 17;
    localparam int SW   = 2 * PIXEL_BITS + 20;
    localparam int NMW  = 2 * PIXEL_BITS + 30;
    localparam int QB   = 16;
    localparam int CW   = SW + QB;
    localparam int FRAC = 12;

    localparam logic [15:0] SAT_POS = 16'h7FFF;
    localparam logic [15:0] SAT_NEG = 16'h8000;

    typedef struct packed {
        logic [NMW-1:0] rem;
        logic [SW-1:0]  dd;
        logic [QB-1:0]  q;
        logic           ovf;
        logic           neg;
    } t_qst;

    // stage 0: magnitudes, rounding numerator 2*|w|*4096 + |den| over 2*|den|
    logic [WW-1:0]  wabs;
    logic [SW-1:0]  dabs;
    logic [NMW-1:0] r_num0;
    logic [SW-1:0]  r_dd0;
    logic           r_neg0;

    assign wabs = i_w[WW-1]   ? $unsigned(~i_w) + WW'(1)   : $unsigned(i_w);
    assign dabs = i_den[SW-1] ? $unsigned(~i_den) + SW'(1) : $unsigned(i_den);

    always_ff @(posedge i_clk) begin
        r_num0 <= (NMW'(wabs[WW-2:0]) << (FRAC + 1)) + NMW'(dabs[SW-2:0]);
        r_dd0  <= {dabs[SW-2:0], 1'b0};
        r_neg0 <= (i_w[WW-1] == i_den[SW-1]);
    end

    t_qst r_st [QB];
    t_qst n_st [QB];

    for (genvar s = 0; s < QB; s++) begin : g_st
        localparam int B = QB - 1 - s;
        t_qst src;
        if (s == 0) begin : g_in
            assign src = '{rem: r_num0, dd: r_dd0, q: '0, ovf: 1'b0, neg: r_neg0};
        end else begin : g_prev
            assign src = r_st[s-1];
        end

        always_comb begin
            logic ovf_c;
            logic ge;
            ovf_c = (s == 0) ? (CW'(src.rem) >= (CW'(src.dd) << QB)) : src.ovf;
            ge    = CW'(src.rem) >= (CW'(src.dd) << B);
            n_st[s]     = src;
            n_st[s].ovf = ovf_c;
            if (ge && !ovf_c) begin
                n_st[s].rem  = NMW'(CW'(src.rem) - (CW'(src.dd) << B));
                n_st[s].q[B] = 1'b1;
            end
        end
    end

    // sign and saturation
    logic [QB:0] mag;
    assign mag = {1'b0, r_st[QB-1].q};

    always_ff @(posedge i_clk) begin
        r_st <= n_st;
        if (r_st[QB-1].neg) begin
            o_coef <= (r_st[QB-1].ovf || mag > 17'd32768) ? $signed(SAT_NEG)
                                                          : $signed(16'(17'd0 - mag));
        end else begin
            o_coef <= (r_st[QB-1].ovf || mag > 17'd32767) ? $signed(SAT_POS)
                                                          : $signed(mag[15:0]);
        end
    end

endmodule

// File: rtl/core/neighbor_affinity_weights.sv
// Channel   Direction  Signals                                   Transaction
// command   in         start, busy, i_pix_*, i_border_mask,      start high, busy low
//                      i_is_feature
// result    out        o_done, o_coef_*, o_present_mask,         o_done high, one cycle
//                      o_sum_zero
// config    in         i_cfg_wr_en, i_cfg_wr_data (weight_mode)  i_cfg_wr_en high
//
// One window enters per clock; busy is always low. Every result leaves after
// its command has passed 6 front stages (stats, linear weight), 17 weight-lane
// stages (8-step index divider plus 8 exp-table multiplies), 3 adder-tree
// stages, 18 stages of the rounding divider, and the output register.
// Reset (synchronous, active low) clears weight_mode and the valid pipe only.
// The result side has no backpressure; nothing in the pipe ever stalls.
module neighbor_affinity_weights #(
    parameter int PIXEL_BITS = naw_pkg::DEF_PIXEL_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_wr_data,
    input  logic [PIXEL_BITS-1:0] i_pix_nw,
    input  logic [PIXEL_BITS-1:0] i_pix_n,
    input  logic [PIXEL_BITS-1:0] i_pix_ne,
    input  logic [PIXEL_BITS-1:0] i_pix_w,
    input  logic [PIXEL_BITS-1:0] i_pix_center,
    input  logic [PIXEL_BITS-1:0] i_pix_e,
    input  logic [PIXEL_BITS-1:0] i_pix_sw,
    input  logic [PIXEL_BITS-1:0] i_pix_s,
    input  logic [PIXEL_BITS-1:0] i_pix_se,
    input  logic [3:0]            i_border_mask,
    input  logic                  i_is_feature,
    output logic                  o_done,
    output logic signed [15:0]    o_coef_nw,
    output logic signed [15:0]    o_coef_n,
    output logic signed [15:0]    o_coef_ne,
    output logic signed [15:0]    o_coef_w,
    output logic signed [15:0]    o_coef_e,
    output logic signed [15:0]    o_coef_sw,
    output logic signed [15:0]    o_coef_s,
    output logic signed [15:0]    o_coef_se,
    output logic [7:0]            o_present_mask,
    output logic                  o_sum_zero
);
    import naw_pkg::*;

    localparam int WW   = 2 * PIXEL_BITS + 17;   // one weight
    localparam int SW   = 2 * PIXEL_BITS + 20;   // weight sum
    localparam int NUMW = 2 * PIXEL_BITS + 13;   // exponent numerator
    localparam int D3W  = 2 * PIXEL_BITS + 8;    // 3*D
    localparam int TOT  = FRONT_LAT + WL_LAT + SUM_LAT + QD_LAT;
    localparam int SIDE = WL_LAT + SUM_LAT;

    // weight_mode: 0 linear correlation, 1 exponential similarity
    logic r_weight_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_weight_mode <= i_cfg_wr_data;
        end
    end

    // fully pipelined, never refuses a command
    assign busy = 1'b0;

    // valid bits travel beside the payload
    logic [TOT-1:0] r_vld;
    logic           r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[TOT-2:0], start & ~busy};
            r_done <= r_vld[TOT-1];
        end
    end

    logic [PIXEL_BITS-1:0] pix [NUM_PIX];

    assign pix = '{i_pix_nw, i_pix_n, i_pix_ne, i_pix_w, i_pix_center,
                   i_pix_e, i_pix_sw, i_pix_s, i_pix_se};

    // front: stats, linear weights, exponent numerators
    logic [NUM_NB-1:0]    f_mask;
    logic                 f_feature;
    logic signed [WW-1:0] f_wl [NUM_NB];
    logic [NUMW-1:0]      f_num [NUM_NB];
    logic [D3W-1:0]       f_div3;

    naw_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
        .i_clk     (i_clk),
        .i_pix     (pix),
        .i_border  (i_border_mask),
        .i_feature (i_is_feature),
        .o_mask    (f_mask),
        .o_feature (f_feature),
        .o_wl      (f_wl),
        .o_num     (f_num),
        .o_div3    (f_div3)
    );

    // per-neighbor weight lanes; absent neighbors come out as zero
    logic signed [WW-1:0] lane_w [NUM_NB];

    for (genvar i = 0; i < NUM_NB; i++) begin : g_wlane
        naw_wlane #(.PIXEL_BITS(PIXEL_BITS)) u_wlane (
            .i_clk  (i_clk),
            .i_num  (f_num[i]),
            .i_div3 (f_div3),
            .i_wl   (f_wl[i]),
            .i_mode (r_weight_mode),
            .i_pres (f_mask[i]),
            .o_w    (lane_w[i])
        );
    end

    logic signed [WW-1:0] sum_w [NUM_NB];
    logic signed [SW-1:0] sum_den;

    naw_sum #(.PIXEL_BITS(PIXEL_BITS)) u_sum (
        .i_clk (i_clk),
        .i_w   (lane_w),
        .o_w   (sum_w),
        .o_den (sum_den)
    );

    // -w/sum per neighbor, Q3.12
    logic signed [15:0] qd_coef [NUM_NB];

    for (genvar i = 0; i < NUM_NB; i++) begin : g_qdiv
        naw_qdiv #(.PIXEL_BITS(PIXEL_BITS)) u_qdiv (
            .i_clk  (i_clk),
            .i_w    (sum_w[i]),
            .i_den  (sum_den),
            .o_coef (qd_coef[i])
        );
    end

    // side info rides along: front output -> sum output -> divider output
    t_side r_sa [SIDE];
    t_tail r_sb [QD_LAT];

    always_ff @(posedge i_clk) begin
        r_sa[0] <= '{feature: f_feature, mask: f_mask};
        for (int k = 1; k < SIDE; k++) r_sa[k] <= r_sa[k-1];
        r_sb[0] <= '{feature: r_sa[SIDE-1].feature, mask: r_sa[SIDE-1].mask,
                     zero: (sum_den == '0)};
        for (int k = 1; k < QD_LAT; k++) r_sb[k] <= r_sb[k-1];
    end

    // output register; a feature pixel or zero sum zeroes all coefficients and an
    // absent neighbor its own; a feature pixel also clears mask and zero flag
    t_tail              tl;
    logic signed [15:0] r_coef [NUM_NB];
    logic [NUM_NB-1:0]  r_pmask;
    logic               r_szero;

    assign tl = r_sb[QD_LAT-1];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_NB; i++) begin
            r_coef[i] <= (tl.feature || tl.zero || !tl.mask[i]) ? 16'sd0 : qd_coef[i];
        end
        r_pmask <= tl.feature ? '0 : tl.mask;
        r_szero <= tl.zero && !tl.feature;
    end

    assign o_done         = r_done;
    assign o_coef_nw      = r_coef[0];
    assign o_coef_n       = r_coef[1];
    assign o_coef_ne      = r_coef[2];
    assign o_coef_w       = r_coef[3];
    assign o_coef_e       = r_coef[4];
    assign o_coef_sw      = r_coef[5];
    assign o_coef_s       = r_coef[6];
    assign o_coef_se      = r_coef[7];
    assign o_present_mask = r_pmask;
    assign o_sum_zero     = r_szero;

endmodule

// File: dv/tb_neighbor_affinity_weights.sv
`timescale 1ns / 100ps

module tb_neighbor_affinity_weights;

    localparam int PIPE_DEPTH = 45;     // command to result, fixed
    localparam int MAX_GAP    = 18;
    localparam int STALL_MAX  = 2000;   // cycles with no transaction before giving up
    localparam int NUM_RAND   = 400;

    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_EXP    = 1'b1;

    // one window and its coefficient set
    typedef struct {
        logic [7:0] pix [9];
        logic [3:0] border;
        logic       feature;
    } t_window;

    typedef struct {
        logic signed [15:0] coef [8];
        logic [7:0]         present;
        logic               zero;
    } t_coefs;

    // directed row: window, mode, and an optional typed-in answer
    typedef struct {
        t_window win;
        logic    mode;
        logic    has_gold;
        t_coefs  gold;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_cfg_wr_en = 1'b0;
    logic i_cfg_wr_data = 1'b0;
    logic [7:0] i_pix_nw = '0, i_pix_n = '0, i_pix_ne = '0, i_pix_w = '0, i_pix_center = '0;
    logic [7:0] i_pix_e = '0, i_pix_sw = '0, i_pix_s = '0, i_pix_se = '0;
    logic [3:0] i_border_mask = '0;
    logic i_is_feature = 1'b0;
    logic o_done;
    logic signed [15:0] o_coef_nw, o_coef_n, o_coef_ne, o_coef_w;
    logic signed [15:0] o_coef_e, o_coef_sw, o_coef_s, o_coef_se;
    logic [7:0] o_present_mask;
    logic o_sum_zero;

    always #2 i_clk = ~i_clk;

    neighbor_affinity_weights uut (
        .i_clk, .i_rst_n, .start, .busy, .i_cfg_wr_en, .i_cfg_wr_data,
        .i_pix_nw, .i_pix_n, .i_pix_ne, .i_pix_w, .i_pix_center,
        .i_pix_e, .i_pix_sw, .i_pix_s, .i_pix_se,
        .i_border_mask, .i_is_feature, .o_done,
        .o_coef_nw, .o_coef_n, .o_coef_ne, .o_coef_w,
        .o_coef_e, .o_coef_sw, .o_coef_s, .o_coef_se,
        .o_present_mask, .o_sum_zero
    );

    // predictor's own copy of the mode register
    logic   mode_shadow = MODE_LINEAR;
    t_coefs pending_coefs[$];
    int     n_errors = 0;
    int     idle_cycles = 0;

    // ---------------------------------------------------------------- predictor
    // exp(-2^j/16) in Q0.16
    function automatic longint exp_q16(longint k);
        longint f [8] = '{61565, 57835, 51039, 39750, 24109, 8869, 1200, 22};
        longint w = 65536;
        if (k >= 256) return 0;
        for (int j = 0; j < 8; j++)
            if (k[j]) w = (w * f[j] + 32768) >>> 16;
        return w;
    endfunction

    // -num/den in Q3.12, nearest with ties away from zero, saturated
    function automatic logic signed [15:0] q12_neg_ratio(longint num, longint den);
        bit     neg = !((num < 0) != (den < 0));
        longint un = num < 0 ? -num : num;
        longint ud = den < 0 ? -den : den;
        longint mag;
        if (un == 0) return 16'sd0;
        mag = (2 * (un <<< 12) + ud) / (2 * ud);
        if (neg) begin
            if (mag > 32768) mag = 32768;
            return 16'(-mag);
        end
        if (mag > 32767) mag = 32767;
        return 16'(mag);
    endfunction

    function automatic t_coefs affinity_coefs(t_window win, logic mode);
        int     nb_pos [8] = '{0, 1, 2, 3, 5, 6, 7, 8};
        longint q [9];
        longint w [8];
        longint n, s, ss, d, den, qc, x, df, k;
        int     cnt, r, c;
        t_coefs res;
        foreach (res.coef[i]) res.coef[i] = '0;
        res.present = '0;
        res.zero    = 1'b0;
        if (win.feature) return res;
        for (int i = 0; i < 9; i++) q[i] = longint'(win.pix[i]) + 1;
        qc  = q[4];
        cnt = 0;
        for (int i = 0; i < 8; i++) begin
            r = nb_pos[i] / 3;
            c = nb_pos[i] % 3;
            if (!((r == 0 && win.border[0]) || (r == 2 && win.border[1]) ||
                  (c == 0 && win.border[2]) || (c == 2 && win.border[3]))) begin
                res.present[i] = 1'b1;
                cnt++;
            end
        end
        if (cnt == 0) begin
            res.zero = 1'b1;
            return res;
        end
        n  = cnt + 1;
        s  = qc;
        ss = qc * qc;
        for (int i = 0; i < 8; i++)
            if (res.present[i]) begin
                s  += q[nb_pos[i]];
                ss += q[nb_pos[i]] * q[nb_pos[i]];
            end
        d = n * ss - s * s;
        if (d <= 0) d = 1;      // flat window
        den = 0;
        for (int i = 0; i < 8; i++) begin
            w[i] = 0;
            x    = q[nb_pos[i]];
            if (res.present[i]) begin
                if (mode == MODE_LINEAR)
                    w[i] = 25 * n * d + (n - 1) * (5 * n * x - 3 * s) * (5 * n * qc - 3 * s);
                else begin
                    df   = x > qc ? x - qc : qc - x;
                    k    = (80 * df * df * n * (n - 1)) / (3 * d);
                    w[i] = exp_q16(k);
                end
                den += w[i];
            end
        end
        if (den == 0) begin
            res.zero = 1'b1;
            return res;
        end
        for (int i = 0; i < 8; i++)
            if (res.present[i]) res.coef[i] = q12_neg_ratio(w[i], den);
        return res;
    endfunction

    // ---------------------------------------------------------------- checking
    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch @%0t: %s got %0d expected %0d", $time, what, got, want);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        logic signed [15:0] seen [8];
        t_coefs want;
        if (o_done) begin
            seen = '{o_coef_nw, o_coef_n, o_coef_ne, o_coef_w,
                     o_coef_e, o_coef_sw, o_coef_s, o_coef_se};
            if (pending_coefs.size() == 0)
                report_mismatch("unexpected result transaction", 1, 0);
            else begin
                want = pending_coefs.pop_front();
                for (int i = 0; i < 8; i++)
                    if (seen[i] !== want.coef[i])
                        report_mismatch($sformatf("coef[%0d]", i), seen[i], want.coef[i]);
                if (o_present_mask !== want.present)
                    report_mismatch("present_mask", o_present_mask, want.present);
                if (o_sum_zero !== want.zero)
                    report_mismatch("sum_zero", o_sum_zero, want.zero);
            end
        end
    end

    // watchdog: any accepted transaction resets the count
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX) begin
            $display("watchdog: no transaction for %0d cycles", STALL_MAX);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- driving
    task automatic write_mode(logic mode);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        mode_shadow = mode;
    endtask

    // drains the pipe; mode change only while nothing is in flight
    task automatic drain_pipe();
        while (pending_coefs.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    // caller is at a falling edge; returns at a falling edge after the accept
    task automatic send_window(t_window win, t_coefs want_c, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        {i_pix_nw, i_pix_n, i_pix_ne, i_pix_w, i_pix_center} <=
            {win.pix[0], win.pix[1], win.pix[2], win.pix[3], win.pix[4]};
        {i_pix_e, i_pix_sw, i_pix_s, i_pix_se} <=
            {win.pix[5], win.pix[6], win.pix[7], win.pix[8]};
        i_border_mask <= win.border;
        i_is_feature  <= win.feature;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
        pending_coefs = {pending_coefs, want_c};
        @(negedge i_clk);
    endtask

    function automatic t_window make_window(logic [7:0] base, logic [7:0] step,
                                            logic [3:0] border, logic feature);
        t_window win;
        for (int i = 0; i < 9; i++) win.pix[i] = 8'(base + step * i);
        win.border  = border;
        win.feature = feature;
        return win;
    endfunction

    function automatic t_window rand_window();
        t_window win;
        int style = $urandom_range(0, 9);
        logic [7:0] base = 8'($urandom_range(0, 255));
        for (int i = 0; i < 9; i++)
            case (style)
                0:       win.pix[i] = base;                                 // flat
                1, 2:    win.pix[i] = 8'(base + $urandom_range(0, 3));      // near flat
                3:       win.pix[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00; // binary edge
                default: win.pix[i] = 8'($urandom_range(0, 255));
            endcase
        // borders mostly legal, sometimes contradictory
        win.border  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'b0000;
        win.feature = ($urandom_range(0, 15) == 0);
        return win;
    endfunction

    // ---------------------------------------------------------------- stimulus
    initial begin
        t_row     rows [$];
        t_row     row;
        t_coefs   want_c;
        t_window  win;
        int       n_sent;
        int       n_dir;

        // after reset the mode is linear; only checked with typed answers
        row = '{win: make_window(8'd0, 8'd0, 4'b0000, 1'b1), mode: MODE_LINEAR,
                has_gold: 1'b1, gold: '{coef: '{default: '0}, present: 8'h00, zero: 1'b0}};
        rows = {rows, row};
        row.win  = make_window(8'd255, 8'd0, 4'b1111, 1'b0);   // no neighbor at all
        row.gold = '{coef: '{default: '0}, present: 8'h00, zero: 1'b1};
        rows = {rows, row};
        // flat, only n and s present: two equal weights, -0.5 each
        row.win  = make_window(8'd7, 8'd0, 4'b1100, 1'b0);
        row.gold = '{coef: '{16'sd0, -16'sd2048, 16'sd0, 16'sd0,
                             16'sd0, 16'sd0, -16'sd2048, 16'sd0},
                     present: 8'h42, zero: 1'b0};
        rows = {rows, row};
        row.has_gold = 1'b0;
        row.win = make_window(8'd0, 8'd0, 4'b0000, 1'b0);      // flat dark
        rows = {rows, row};
        row.win = make_window(8'd255, 8'd0, 4'b0000, 1'b0);    // flat bright
        rows = {rows, row};
        row.win = make_window(8'd0, 8'd31, 4'b0000, 1'b0);     // ramp
        rows = {rows, row};
        row.win = make_window(8'd255, 8'd225, 4'b0101, 1'b0);  // corner, wraps
        rows = {rows, row};
        row.win = make_window(8'd1, 8'd85, 4'b1010, 1'b0);
        rows = {rows, row};
        row.win = make_window(8'hAA, 8'h55, 4'b0001, 1'b0);
        rows = {rows, row};
        row.win = make_window(8'd0, 8'd0, 4'b0000, 1'b0);
        row.win.pix[4] = 8'd255;                               // lone bright center
        rows = {rows, row};
        n_dir = rows.size();
        for (int i = 3; i < n_dir; i++) begin
            row = rows[i];
            row.mode = MODE_EXP;
            rows = {rows, row};
        end
        row.mode = MODE_EXP;
        row.win  = make_window(8'd0, 8'd0, 4'b0000, 1'b0);
        row.win.pix[0] = 8'd255;                               // one outlier, weight vanishes
        rows = {rows, row};
        row.win = make_window(8'd0, 8'd0, 4'b0011, 1'b0);
        rows = {rows, row};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table, with the mode rewritten whenever a row asks for another
        foreach (rows[i]) begin
            if (rows[i].mode != mode_shadow || i == 0) begin
                start <= 1'b0;
                drain_pipe();
                write_mode(rows[i].mode);
            end
            if (rows[i].has_gold)
                want_c = rows[i].gold;
            else
                want_c = affinity_coefs(rows[i].win, rows[i].mode);
            send_window(rows[i].win, want_c, $urandom_range(0, 2));
        end

        // random phases, alternating mode
        n_sent = 0;
        for (int phase = 0; phase < 4; phase++) begin
            start <= 1'b0;
            drain_pipe();
            write_mode(phase[0] ? MODE_LINEAR : MODE_EXP);
            for (int j = 0; j < NUM_RAND / 4; j++) begin
                win = rand_window();
                // bursts with no gaps, then gappy stretches
                send_window(win, affinity_coefs(win, mode_shadow),
                            (j % 40 < 12) ? 0 : $urandom_range(0, MAX_GAP));
                n_sent++;
            end
        end
        start <= 1'b0;

        while (pending_coefs.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
